### src/q_learning_grid_step_top_assert.svh
// Assertion macros for the grid Q-learning step block
`ifndef Q_LEARNING_GRID_STEP_TOP_ASSERT_SVH
`define Q_LEARNING_GRID_STEP_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define QL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define QL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### src/qlg_pkg.sv
// Package: request codes, cell kinds, configuration indexes and word types
`timescale 1ns / 1ps
package qlg_pkg;
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_STEP  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] CELL_OBST   = 2'd0;
    localparam logic [1:0] CELL_FREE   = 2'd1;
    localparam logic [1:0] CELL_CHARGE = 2'd2;
    localparam logic [1:0] CELL_BAD    = 2'd3;

    localparam logic [2:0] CFG_LR    = 3'd0;
    localparam logic [2:0] CFG_DISC  = 3'd1;
    localparam logic [2:0] CFG_GOAL  = 3'd2;
    localparam logic [2:0] CFG_BUMP  = 3'd3;
    localparam logic [2:0] CFG_STEP  = 3'd4;
    localparam logic [2:0] CFG_ROWS  = 3'd5;
    localparam logic [2:0] CFG_COLS  = 3'd6;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] row;
        logic [5:0] col;
        logic [2:0] action;
        logic [1:0] cell_kind;
    } req_word_t;

    typedef struct packed {
        logic [5:0]         new_row;
        logic [5:0]         new_col;
        logic               moved;
        logic signed [7:0]  reward;
        logic               arrived;
        logic signed [31:0] q_value;
        logic [2:0]         greedy_action;
        logic               status;
    } rsp_word_t;

    // Row and column offsets of the eight moves, N then clockwise
    function automatic logic signed [1:0] move_dr(input logic [2:0] a);
        case (a)
            3'd0, 3'd1, 3'd7: move_dr = -2'sd1;
            3'd3, 3'd4, 3'd5: move_dr = 2'sd1;
            default:          move_dr = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] move_dc(input logic [2:0] a);
        case (a)
            3'd1, 3'd2, 3'd3: move_dc = 2'sd1;
            3'd5, 3'd6, 3'd7: move_dc = -2'sd1;
            default:          move_dc = 2'sd0;
        endcase
    endfunction
endpackage

### src/qlg_req_if.sv
// Valid/ready channel carrying request words
`timescale 1ns / 1ps
interface qlg_req_if;
    import qlg_pkg::*;
    logic      valid;
    logic      ready;
    req_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/qlg_rsp_if.sv
// Valid/ready channel carrying result words
`timescale 1ns / 1ps
interface qlg_rsp_if;
    import qlg_pkg::*;
    logic      valid;
    logic      ready;
    rsp_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/qlg_mac.sv
// Shared multiply-accumulate unit: acc + floor(v * f / 2^16), one product per call
`timescale 1ns / 1ps
module qlg_mac #(
    parameter int VW = 50
) (
    input  logic                 clk,
    input  logic                 start,
    input  logic signed [VW-1:0] v,
    input  logic [15:0]          f,
    input  logic signed [VW-1:0] acc,
    output logic signed [VW-1:0] res
);
    // Split v into a high part and a 16-bit fraction so the product stays exact
    logic signed [VW-17:0] hi;
    logic [15:0]           lo;
    logic signed [VW-1:0]  prod_hi_reg;
    logic [15:0]           prod_lo_reg;
    logic signed [VW-1:0]  acc_reg;
    logic [31:0]           lo_full;

    assign hi      = v[VW-1:16];
    assign lo      = v[15:0];
    assign lo_full = {16'd0, lo} * {16'd0, f};

    // Register the partial products, then add
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_hi_reg <= VW'(hi * $signed({1'b0, f}));
            prod_lo_reg <= lo_full[31:16];
            acc_reg     <= acc;
        end
    end

    assign res = acc_reg + prod_hi_reg + $signed({{(VW-16){1'b0}}, prod_lo_reg});
endmodule

### src/q_learning_grid_step_top.sv
// Top level: grid store, Q-table, sequencer and shared multiply unit
//
// Usage. Requests arrive on req (valid/ready) with req_type, row, col, action
// and cell_kind; one result word leaves on rsp for every request. The user
// must write registers on cfg_we/cfg_idx/cfg_data only while idle, unchecked.
// From acceptance to rsp.valid, query makes one read of the cell's row of
// eight Q words and eight compares; step makes one grid read for the target,
// one for the landing cell, one read of the landing row and eight compares,
// two passes through the shared multiplier and one write-back. Clear sweeps
// the table one row of eight words per cycle.
// The block holds one request at a time; ready is low while it works or
// while a result waits in the output register, so the next request is taken
// only after the result word has left on rsp.
// Reset: registers take their reset values and a clearing pass runs over
// the grid and the Q-table, during which no request is taken; configuration
// writes are taken throughout.
// Stall: a result stays in the output register until rsp.ready is high.
`timescale 1ns / 1ps
module q_learning_grid_step_top #(
    parameter int ROWS    = 64,
    parameter int COLS    = 64,
    parameter int Q_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    qlg_req_if.sink                           req,
    qlg_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [qlg_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [qlg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import qlg_pkg::*;
    `include "q_learning_grid_step_top_assert.svh"

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int NCELL = ROWS * COLS;
    localparam int AW    = $clog2(NCELL);
    localparam int VW    = Q_WIDTH + 18;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DEC   = 5'd2;
    localparam logic [4:0] S_TGT   = 5'd3;
    localparam logic [4:0] S_TGTW  = 5'd4;
    localparam logic [4:0] S_LAND  = 5'd5;
    localparam logic [4:0] S_LANDW = 5'd6;
    localparam logic [4:0] S_QRD   = 5'd7;
    localparam logic [4:0] S_QACC  = 5'd8;
    localparam logic [4:0] S_M1    = 5'd9;
    localparam logic [4:0] S_M1W   = 5'd10;
    localparam logic [4:0] S_M2    = 5'd11;
    localparam logic [4:0] S_M2W   = 5'd12;
    localparam logic [4:0] S_WB    = 5'd13;
    localparam logic [4:0] S_OUT   = 5'd14;
    localparam logic [4:0] S_CLRQ  = 5'd15;

    // Configuration registers
    logic [15:0]       lr_reg, disc_reg;
    logic signed [7:0] goal_reg, bump_reg, stepp_reg;
    logic [6:0]        rows_reg, cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg    <= 16'd13107;
            disc_reg  <= 16'd58982;
            goal_reg  <= 8'sd30;
            bump_reg  <= -8'sd10;
            stepp_reg <= -8'sd1;
            rows_reg  <= 7'd50;
            cols_reg  <= 7'd50;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_LR:   lr_reg    <= cfg_data;
                CFG_DISC: disc_reg  <= cfg_data;
                CFG_GOAL: goal_reg  <= cfg_data[7:0];
                CFG_BUMP: bump_reg  <= cfg_data[7:0];
                CFG_STEP: stepp_reg <= cfg_data[7:0];
                CFG_ROWS: rows_reg  <= cfg_data[6:0];
                CFG_COLS: cols_reg  <= cfg_data[6:0];
                default:  ;
            endcase
        end
    end

    // Limits of the used area
    logic [8:0] nr, nc;
    assign nr = ({2'b0, rows_reg} < 9'(ROWS)) ? {2'b0, rows_reg} : 9'(ROWS);
    assign nc = ({2'b0, cols_reg} < 9'(COLS)) ? {2'b0, cols_reg} : 9'(COLS);

    // Memories: grid cells and Q-table rows of eight entries
    logic [1:0]                  maze_mem [NCELL];
    logic [8*Q_WIDTH-1:0]        q_mem    [NCELL];
    logic [AW-1:0]               m_addr, q_addr;
    logic                        m_we, q_we;
    logic [1:0]                  m_wdata, m_rdata_reg;
    logic [8*Q_WIDTH-1:0]        q_wdata, q_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (m_we)
            maze_mem[m_addr] <= m_wdata;
        m_rdata_reg <= maze_mem[m_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_addr] <= q_wdata;
        q_rdata_reg <= q_mem[q_addr];
    end

    // Sequencer state
    logic [4:0]              st_reg, st_next;
    logic [AW:0]             cnt_reg, cnt_next;
    req_word_t               in_reg, in_next;
    rsp_word_t               out_reg, out_next;
    logic                    ov_reg, ov_next;
    logic [RW-1:0]           lr_row_reg, lr_row_next;
    logic [CW-1:0]           lc_reg, lc_next;
    logic                    mv_reg, mv_next;
    logic signed [VW-1:0]    maxq_reg, maxq_next;
    logic signed [VW-1:0]    qs_reg, qs_next;
    logic [2:0]              best_reg, best_next;
    logic [3:0]              ai_reg, ai_next;
    logic [8*Q_WIDTH-1:0]    srow_reg, srow_next;
    logic signed [VW-1:0]    d_reg, d_next;

    // Shared multiply unit
    logic                    mac_start;
    logic signed [VW-1:0]    mac_v, mac_acc, mac_res;
    logic [15:0]             mac_f;

    qlg_mac #(.VW(VW)) u_mac (
        .clk   (clk),
        .start (mac_start),
        .v     (mac_v),
        .f     (mac_f),
        .acc   (mac_acc),
        .res   (mac_res)
    );

    // Address helpers
    logic [AW-1:0]         s_addr, l_addr, t_addr;
    logic signed [9:0]     tr, tc;
    logic                  t_in;
    logic                  pos_ok;
    logic signed [Q_WIDTH-1:0] qe;
    logic signed [VW-1:0]  qmaxv, qminv, nq;

    assign tr = $signed({4'b0, in_reg.row}) + 10'(move_dr(in_reg.action));
    assign tc = $signed({4'b0, in_reg.col}) + 10'(move_dc(in_reg.action));
    assign t_in = (tr >= 0) && (tc >= 0) && (tr < $signed({1'b0, nr}))
                  && (tc < $signed({1'b0, nc}));
    assign pos_ok = ({3'b0, in_reg.row} < nr) && ({3'b0, in_reg.col} < nc);
    assign qe = q_rdata_reg[ai_reg[2:0]*Q_WIDTH +: Q_WIDTH];
    assign qmaxv = VW'((64'sd1 <<< (Q_WIDTH - 1)) - 1);
    assign qminv = -qmaxv - 1;
    assign nq = (mac_res > qmaxv) ? qmaxv : ((mac_res < qminv) ? qminv : mac_res);

    function automatic logic [AW-1:0] cell_addr(input logic [9:0] r, input logic [9:0] c);
        logic [19:0] a;
        a = 20'(r) * 20'(COLS) + 20'(c);
        cell_addr = a[AW-1:0];
    endfunction

    assign s_addr = cell_addr(10'(in_reg.row), 10'(in_reg.col));

    always_comb
    begin
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        in_next     = in_reg;
        out_next    = out_reg;
        ov_next     = ov_reg;
        lr_row_next = lr_row_reg;
        lc_next     = lc_reg;
        mv_next     = mv_reg;
        maxq_next   = maxq_reg;
        qs_next     = qs_reg;
        best_next   = best_reg;
        ai_next     = ai_reg;
        srow_next   = srow_reg;
        d_next      = d_reg;
        m_addr      = cell_addr(10'(in_reg.row), 10'(in_reg.col));
        m_we        = 1'b0;
        m_wdata     = (in_reg.cell_kind == CELL_BAD) ? CELL_OBST : in_reg.cell_kind;
        q_addr      = cell_addr(10'(in_reg.row), 10'(in_reg.col));
        q_we        = 1'b0;
        q_wdata     = srow_reg;
        mac_start   = 1'b0;
        mac_v       = maxq_reg;
        mac_f       = disc_reg;
        mac_acc     = '0;
        t_addr      = cell_addr(10'(tr), 10'(tc));
        l_addr      = cell_addr(10'(lr_row_reg), 10'(lc_reg));

        // Drop the result word once taken
        if (ov_reg && rsp.ready)
            ov_next = 1'b0;

        case (st_reg)
            S_CLR, S_CLRQ:
            begin
                // Sweep one row of the table (and grid after reset) per cycle
                m_addr  = cnt_reg[AW-1:0];
                q_addr  = cnt_reg[AW-1:0];
                m_we    = (st_reg == S_CLR);
                m_wdata = CELL_OBST;
                q_we    = 1'b1;
                q_wdata = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(NCELL - 1))
                    st_next = (st_reg == S_CLR) ? S_IDLE : S_OUT;
            end
            S_IDLE:
            begin
                if (req.valid && !ov_reg)
                begin
                    in_next = req.data;
                    st_next = S_DEC;
                end
            end
            S_DEC:
            begin
                out_next = '0;
                out_next.new_row = in_reg.row;
                out_next.new_col = in_reg.col;
                if (in_reg.req_type == REQ_CLEAR)
                begin
                    cnt_next = '0;
                    st_next  = S_CLRQ;
                end
                else if (!pos_ok)
                begin
                    out_next.status = 1'b1;
                    st_next = S_OUT;
                end
                else if (in_reg.req_type == REQ_LOAD)
                begin
                    m_we    = 1'b1;
                    st_next = S_OUT;
                end
                else if (in_reg.req_type == REQ_QUERY)
                begin
                    st_next = S_QRD;
                    ai_next = '0;
                    lr_row_next = RW'(in_reg.row);
                    lc_next = CW'(in_reg.col);
                end
                else
                begin
                    st_next = S_TGT;
                end
            end
            S_TGT:
            begin
                m_addr = t_addr;
                q_addr = s_addr;
                st_next = S_TGTW;
            end
            S_TGTW:
            begin
                // Keep the start row of the table for write-back
                srow_next = q_rdata_reg;
                qs_next = VW'($signed(q_rdata_reg[in_reg.action*Q_WIDTH +: Q_WIDTH]));
                if (t_in && (m_rdata_reg == CELL_FREE || m_rdata_reg == CELL_CHARGE))
                begin
                    lr_row_next = RW'(tr);
                    lc_next     = CW'(tc);
                    mv_next     = 1'b1;
                end
                else
                begin
                    lr_row_next = RW'(in_reg.row);
                    lc_next     = CW'(in_reg.col);
                    mv_next     = 1'b0;
                end
                st_next = S_LAND;
            end
            S_LAND:
            begin
                m_addr = l_addr;
                q_addr = l_addr;
                st_next = S_LANDW;
            end
            S_LANDW:
            begin
                // Hold the landing row on the table port for the scan
                q_addr = l_addr;
                out_next.new_row = 6'(lr_row_reg);
                out_next.new_col = 6'(lc_reg);
                out_next.moved   = mv_reg;
                if (m_rdata_reg == CELL_CHARGE)
                begin
                    out_next.reward  = goal_reg;
                    out_next.arrived = 1'b1;
                end
                else if (!mv_reg)
                    out_next.reward = bump_reg;
                else
                    out_next.reward = stepp_reg;
                ai_next = '0;
                st_next = S_QACC;
            end
            S_QRD:
            begin
                q_addr  = l_addr;
                st_next = S_QACC;
            end
            S_QACC:
            begin
                // Scan the eight entries, one compare per cycle
                q_addr = l_addr;
                if (ai_reg == 4'd0 || VW'(qe) > maxq_reg)
                begin
                    maxq_next = VW'(qe);
                    best_next = ai_reg[2:0];
                end
                ai_next = ai_reg + 1'b1;
                if (ai_reg == 4'd7)
                    st_next = (in_reg.req_type == REQ_QUERY) ? S_OUT : S_M1;
                if (ai_reg == 4'd7 && in_reg.req_type == REQ_QUERY)
                begin
                    out_next.greedy_action = (ai_reg == 4'd0 || VW'(qe) > maxq_reg)
                                             ? 3'd7 : best_reg;
                    out_next.q_value = 32'((ai_reg == 4'd0 || VW'(qe) > maxq_reg)
                                           ? VW'(qe) : maxq_reg);
                end
            end
            S_M1:
            begin
                // d = r*2^16 + floor(g*maxQ) - Q
                mac_start = 1'b1;
                mac_v     = maxq_reg;
                mac_f     = disc_reg;
                mac_acc   = ($signed({{(VW-24){out_reg.reward[7]}}, out_reg.reward, 16'd0}))
                            - qs_reg;
                st_next   = S_M1W;
            end
            S_M1W:
            begin
                d_next  = mac_res;
                st_next = S_M2;
            end
            S_M2:
            begin
                mac_start = 1'b1;
                mac_v     = d_reg;
                mac_f     = lr_reg;
                mac_acc   = qs_reg;
                st_next   = S_M2W;
            end
            S_M2W:
            begin
                srow_next[in_reg.action*Q_WIDTH +: Q_WIDTH] = nq[Q_WIDTH-1:0];
                out_next.q_value = 32'(nq);
                st_next = S_WB;
            end
            S_WB:
            begin
                q_addr  = s_addr;
                q_we    = 1'b1;
                q_wdata = srow_reg;
                st_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLR;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
            ai_reg  <= '0;
            mv_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
            ai_reg  <= ai_next;
            mv_reg  <= mv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        out_reg    <= out_next;
        lr_row_reg <= lr_row_next;
        lc_reg     <= lc_next;
        maxq_reg   <= maxq_next;
        qs_reg     <= qs_next;
        best_reg   <= best_next;
        srow_reg   <= srow_next;
        d_reg      <= d_next;
    end

    assign req.ready = (st_reg == S_IDLE) && !ov_reg;
    assign rsp.valid = ov_reg;
    assign rsp.data  = out_reg;

    `QL_ASSERT_IMP(a_ready_idle, req.ready, st_reg == S_IDLE)
    `QL_ASSERT_NXT(a_take_dec, req.valid && req.ready, st_reg == S_DEC)
    `QL_ASSERT_IMP(a_no_we_idle, st_reg == S_IDLE, !q_we && !m_we)
endmodule

### tb/sv/q_learning_grid_step_top_tb.sv
// Testbench for the grid Q-learning step block: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module q_learning_grid_step_top_tb;
    import qlg_pkg::*;

    localparam int GRID_R  = 64;
    localparam int GRID_C  = 64;
    localparam int N_ACT   = 8;
    localparam int SETTLE  = 40;
    localparam int HOLD_LEN = 300;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    qlg_req_if req ();
    qlg_rsp_if rsp ();

    q_learning_grid_step_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req.sink),
        .rsp      (rsp.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Predictor state: grid, Q-table and register copies
    logic [1:0]     maze_m [GRID_R*GRID_C];
    longint         qtab_m [GRID_R*GRID_C*N_ACT];
    logic [15:0]    lr_m;
    logic [15:0]    disc_m;
    logic [7:0]     goal_m;
    logic [7:0]     bump_m;
    logic [7:0]     stepr_m;
    logic [6:0]     rows_m;
    logic [6:0]     cols_m;
    const int       row_off [N_ACT] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    const int       col_off [N_ACT] = '{0, 1, 1, 1, 0, -1, -1, -1};

    rsp_word_t      expected_words [$];
    int             n_fail;
    int             n_words;
    int             n_steps;
    int             n_moved;
    int             n_arrived;
    int             n_outside;
    int             n_sat;
    bit             no_idle;
    bit             hold_trigger;
    int             hold_left;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Give up after a generous time
    initial
    begin
        #8ms;
        $display("tb: failure");
        $finish;
    end

    // Floor of v*f/65536; arithmetic shift is an exact floor
    function automatic longint frac_mul(longint v, longint f);
        return (v * f) >>> 16;
    endfunction

    // Work out the result word of one request and advance the predicted state
    function automatic rsp_word_t grid_predict(req_word_t w);
        rsp_word_t o;
        int nr, nc, tr, tc, lrow, lcol, sidx, lbase, base, best;
        logic [1:0] grid_kind;
        longint r, maxq, d, nq;
        o = '0;
        o.new_row = w.row;
        o.new_col = w.col;
        nr = (rows_m > GRID_R) ? GRID_R : rows_m;
        nc = (cols_m > GRID_C) ? GRID_C : cols_m;
        if (w.req_type == REQ_CLEAR)
        begin
            foreach (qtab_m[i]) qtab_m[i] = 0;
        end
        else if (!(w.row < nr && w.col < nc))
        begin
            o.status = 1'b1;
            n_outside++;
        end
        else if (w.req_type == REQ_LOAD)
        begin
            maze_m[w.row*GRID_C + w.col] = (w.cell_kind == CELL_BAD) ? CELL_OBST : w.cell_kind;
        end
        else if (w.req_type == REQ_QUERY)
        begin
            base = (w.row*GRID_C + w.col) * N_ACT;
            best = 0;
            for (int a = 1; a < N_ACT; a++)
                if (qtab_m[base+a] > qtab_m[base+best]) best = a;
            o.greedy_action = best[2:0];
            o.q_value = qtab_m[base+best][31:0];
        end
        else
        begin
            n_steps++;
            tr = int'(w.row) + row_off[w.action];
            tc = int'(w.col) + col_off[w.action];
            lrow = w.row;
            lcol = w.col;
            if (tr >= 0 && tc >= 0 && tr < nr && tc < nc)
            begin
                grid_kind = maze_m[tr*GRID_C + tc];
                if (grid_kind == CELL_FREE || grid_kind == CELL_CHARGE)
                begin
                    lrow = tr;
                    lcol = tc;
                    o.moved = 1'b1;
                end
            end
            grid_kind = maze_m[lrow*GRID_C + lcol];
            if (grid_kind == CELL_CHARGE)
            begin
                r = longint'($signed(goal_m));
                o.arrived = 1'b1;
            end
            else if (!o.moved)
                r = longint'($signed(bump_m));
            else
                r = longint'($signed(stepr_m));
            lbase = (lrow*GRID_C + lcol) * N_ACT;
            maxq = qtab_m[lbase];
            for (int a = 1; a < N_ACT; a++)
                if (qtab_m[lbase+a] > maxq) maxq = qtab_m[lbase+a];
            sidx = (w.row*GRID_C + w.col) * N_ACT + w.action;
            d = r * 65536 + frac_mul(maxq, disc_m) - qtab_m[sidx];
            nq = qtab_m[sidx] + frac_mul(d, lr_m);
            if (nq > 64'sh7FFF_FFFF)
            begin
                nq = 64'sh7FFF_FFFF;
                n_sat++;
            end
            else if (nq < -64'sh8000_0000)
            begin
                nq = -64'sh8000_0000;
                n_sat++;
            end
            qtab_m[sidx] = nq;
            o.new_row = lrow[5:0];
            o.new_col = lcol[5:0];
            o.reward = r[7:0];
            o.q_value = nq[31:0];
            n_moved += o.moved;
            n_arrived += o.arrived;
        end
        return o;
    endfunction

    function automatic void reset_model();
        foreach (maze_m[i]) maze_m[i] = CELL_OBST;
        foreach (qtab_m[i]) qtab_m[i] = 0;
        lr_m = 16'd13107;
        disc_m = 16'd58982;
        goal_m = 8'd30;
        bump_m = 8'hF6;
        stepr_m = 8'hFF;
        rows_m = 7'd50;
        cols_m = 7'd50;
    endfunction

    // Send one request word; the prediction is made at acceptance.
    // Valid stays high afterwards until the next word, a pause or a drain replaces it.
    task automatic send_req(logic [1:0] kind, int row, int col, int act, int ck);
        req_word_t w;
        bit taken;
        w.req_type = kind;
        w.row = row[5:0];
        w.col = col[5:0];
        w.action = act[2:0];
        w.cell_kind = ck[1:0];
        if (!no_idle && $urandom_range(99) < 10)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= w;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = req.ready;
            @(posedge clk);
        end
        expected_words = {expected_words, grid_predict(w)};
    endtask

    // Drop the request, hold until every expected word has arrived, then let the block settle
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val[15:0];
        @(posedge clk);
        case (idx)
            CFG_LR:   lr_m = val[15:0];
            CFG_DISC: disc_m = val[15:0];
            CFG_GOAL: goal_m = val[7:0];
            CFG_BUMP: bump_m = val[7:0];
            CFG_STEP: stepr_m = val[7:0];
            CFG_ROWS: rows_m = val[6:0];
            CFG_COLS: cols_m = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_all_regs(int lr, int dc, int gr, int bp, int sp, int nr, int nc);
        wait_drained();
        write_reg(CFG_LR, lr);
        write_reg(CFG_DISC, dc);
        write_reg(CFG_GOAL, gr);
        write_reg(CFG_BUMP, bp);
        write_reg(CFG_STEP, sp);
        write_reg(CFG_ROWS, nr);
        write_reg(CFG_COLS, nc);
        cfg_we <= 1'b0;
    endtask

    // Random mix inside an area of ar x ac cells, with some noise anywhere
    task automatic random_items(int n, int ar, int ac);
        int pick, r, c;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8 || ar == 0 || ac == 0)
            begin
                r = $urandom_range(63);
                c = $urandom_range(63);
            end
            else
            begin
                r = $urandom_range(ar - 1);
                c = $urandom_range(ac - 1);
            end
            if (pick < 25)
                send_req(REQ_LOAD, r, c, $urandom_range(7),
                         ($urandom_range(9) < 6) ? CELL_FREE : $urandom_range(3));
            else if (pick < 80)
                send_req(REQ_STEP, r, c, $urandom_range(7), $urandom_range(3));
            else
                send_req(REQ_QUERY, r, c, $urandom_range(7), $urandom_range(3));
        end
    endtask

    // Drive the result ready with random stalls and an occasional long hold
    always @(posedge clk)
    begin
        if (hold_trigger)
        begin
            hold_left = HOLD_LEN;
            hold_trigger = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= no_idle || ($urandom_range(99) >= 10);
    end

    // Compare each accepted result word with the oldest expectation
    always @(negedge clk)
    begin
        rsp_word_t e;
        rsp_word_t a;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            a = rsp.data;
            n_words++;
            if (expected_words.size() == 0)
            begin
                $error("result word with no request waiting");
                n_fail++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (a.new_row !== e.new_row)
                begin
                    $error("new_row: expected %0d, got %0d", e.new_row, a.new_row); n_fail++;
                end
                if (a.new_col !== e.new_col)
                begin
                    $error("new_col: expected %0d, got %0d", e.new_col, a.new_col); n_fail++;
                end
                if (a.moved !== e.moved)
                begin
                    $error("moved: expected %0d, got %0d", e.moved, a.moved); n_fail++;
                end
                if (a.reward !== e.reward)
                begin
                    $error("reward: expected %0d, got %0d", e.reward, a.reward); n_fail++;
                end
                if (a.arrived !== e.arrived)
                begin
                    $error("arrived: expected %0d, got %0d", e.arrived, a.arrived); n_fail++;
                end
                if (a.q_value !== e.q_value)
                begin
                    $error("q_value: expected %0d, got %0d", e.q_value, a.q_value); n_fail++;
                end
                if (a.greedy_action !== e.greedy_action)
                begin
                    $error("greedy_action: expected %0d, got %0d",
                           e.greedy_action, a.greedy_action); n_fail++;
                end
                if (a.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, a.status); n_fail++;
                end
            end
        end
    end

    // Corner cases on the reset configuration: ties, bumps, charging, bounds, clear
    task automatic test_directed();
        send_req(REQ_LOAD, 0, 0, 0, CELL_FREE);
        send_req(REQ_LOAD, 0, 1, 0, CELL_CHARGE);
        send_req(REQ_LOAD, 1, 0, 0, CELL_BAD);
        send_req(REQ_LOAD, 1, 1, 0, CELL_FREE);
        send_req(REQ_LOAD, 49, 49, 7, CELL_FREE);
        send_req(REQ_QUERY, 0, 0, 0, 0);
        send_req(REQ_STEP, 0, 0, 2, 0);
        send_req(REQ_STEP, 0, 1, 6, 0);
        send_req(REQ_STEP, 0, 0, 0, 0);
        send_req(REQ_STEP, 0, 1, 0, 0);
        send_req(REQ_STEP, 0, 0, 4, 0);
        for (int a = 0; a < N_ACT; a++)
            send_req(REQ_STEP, 1, 1, a, 0);
        send_req(REQ_QUERY, 1, 1, 0, 0);
        send_req(REQ_STEP, 49, 49, 3, 0);
        send_req(REQ_LOAD, 50, 0, 0, CELL_FREE);
        send_req(REQ_STEP, 0, 63, 4, 3);
        send_req(REQ_QUERY, 63, 63, 0, 0);
        send_req(REQ_CLEAR, 63, 63, 7, 3);
        send_req(REQ_QUERY, 1, 1, 0, 0);
    endtask

    // Repeated bumps on a charging cell with full rates push Q to the top
    task automatic test_saturation();
        set_all_regs(16'hFFFF, 16'hFFFF, 127, -128, 127, 4, 4);
        send_req(REQ_LOAD, 0, 0, 0, CELL_CHARGE);
        for (int i = 0; i < 320; i++)
            send_req(REQ_STEP, 0, 0, 0, 0);
        send_req(REQ_QUERY, 0, 0, 0, 0);
    endtask

    // Small area on default rates, first stretch with no idling
    task automatic test_small_area();
        no_idle = 1'b1;
        random_items(60, 6, 6);
        no_idle = 1'b0;
        random_items(90, 6, 6);
    endtask

    // Extreme rates and rewards on a narrow area, then a clear
    task automatic test_extremes();
        set_all_regs(16'hFFFF, 16'hFFFF, 127, -128, 127, 8, 5);
        random_items(200, 8, 5);
        send_req(REQ_CLEAR, 3, 2, 1, 1);
        random_items(20, 8, 5);
    endtask

    // Zero rows in use: every position is outside
    task automatic test_empty_area();
        set_all_regs(0, 0, -128, 127, -128, 0, 64);
        random_items(40, 0, 0);
    endtask

    // Register above the grid size, full range of positions, with back-pressure
    task automatic test_full_grid();
        set_all_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(255),
                     $urandom_range(255), $urandom_range(255), 127, 127);
        random_items(60, 64, 64);
        hold_trigger = 1'b1;
        random_items(50, 64, 64);
        wait_drained();
        random_items(60, 64, 64);
    endtask

    // Tall and narrow, then random settings on small random areas
    task automatic test_random_settings();
        int ar, ac;
        set_all_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(255),
                     $urandom_range(255), $urandom_range(255), 64, 1);
        random_items(60, 64, 1);
        for (int p = 0; p < 4; p++)
        begin
            ar = $urandom_range(1, 12);
            ac = $urandom_range(1, 12);
            set_all_regs($urandom_range(65535), $urandom_range(65535), $urandom_range(255),
                         $urandom_range(255), $urandom_range(255), ar, ac);
            random_items(30, ar, ac);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
        n_fail = 0;
        n_words = 0;
        n_steps = 0;
        n_moved = 0;
        n_arrived = 0;
        n_outside = 0;
        n_sat = 0;
        no_idle = 1'b0;
        hold_trigger = 1'b0;
        hold_left = 0;
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_small_area();
        test_extremes();
        test_empty_area();
        test_full_grid();
        test_random_settings();
        test_saturation();

        wait_drained();
        $display("tb: %0d result words checked, %0d steps (%0d moved, %0d arrived)",
                 n_words, n_steps, n_moved, n_arrived);
        $display("tb: %0d outside-area requests, %0d saturated updates", n_outside, n_sat);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
